/* hw/rtl/gexp_pkg.sv */
// gexp_pkg: types, fixed-point constants and limits shared by the gaussian
// exp taylor series block. no dependencies.
`timescale 1ns / 1ps

package gexp_pkg;

   localparam int MAX_TERMS = 64;

   typedef logic signed [15:0] arg_x_type;
   typedef logic signed [31:0] series_sum_type;
   typedef logic [6:0]         terms_used_type;
   typedef logic [31:0]        eps_type;

   localparam eps_type        EPS_RESET = 32'd4096;
   localparam logic [63:0]    ONE_Q40   = 64'h0000_0100_0000_0000;
   localparam logic [63:0]    MAG_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam series_sum_type SUM_MAX   = 32'sh7FFF_FFFF;
   localparam series_sum_type SUM_MIN   = 32'sh8000_0000;
   localparam terms_used_type TERM_CAP  = terms_used_type'(MAX_TERMS);

endpackage

/* hw/rtl/gaussian_exp_taylor_series_top.sv */
// gaussian_exp_taylor_series_top: e^(-x^2) by taylor series on one shared
// 32x32 multiplier and an 8-bit-per-cycle divider under a small sequencer.
// depends on gexp_pkg.
//
// usage:
//  req channel: one beat carries req_arg_x (signed q2.13). a beat is taken
//   when req_valid is high and req_stall is low; req_stall is low only while
//   the sequencer is idle, so one argument is worked on at a time.
//  rsp channel: one beat per argument with rsp_series_sum (signed q1.30,
//   saturated), rsp_terms_used and rsp_hit_cap. the result sits in an output
//   register; while rsp_stall is high it holds, and the next argument may
//   already be taken and computed, finishing only when that register frees.
//  csr channel: csr_wdata writes the eps threshold when csr_valid is high;
//   csr_ready is always high. write only while the block is idle.
//  sequence: after the request beat the argument is squared; then each term
//   passes through two multiplier passes, one saturation, divide steps at
//   8 quotient bits each until all 64 quotient bits are formed, one
//   accumulate and one stop check; at most 64 terms are used. a new argument
//   is taken only once the previous one has left the sequencer.
//  reset: synchronous, active high; clears the sequencer and the response
//   valid and loads eps with 4096 (2^-20).
`timescale 1ns / 1ps

module gaussian_exp_taylor_series_top (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  gexp_pkg::arg_x_type       req_arg_x,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output gexp_pkg::series_sum_type  rsp_series_sum,
   output gexp_pkg::terms_used_type  rsp_terms_used,
   output logic                      rsp_hit_cap,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  gexp_pkg::eps_type         csr_wdata
);

   import gexp_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_SQ   = 4'd1;
   localparam logic [3:0] S_CHK  = 4'd2;
   localparam logic [3:0] S_MLO  = 4'd3;
   localparam logic [3:0] S_MHI  = 4'd4;
   localparam logic [3:0] S_SAT  = 4'd5;
   localparam logic [3:0] S_DIV  = 4'd6;
   localparam logic [3:0] S_ACC  = 4'd7;
   localparam logic [3:0] S_OUT  = 4'd8;

   logic [3:0]     state_ff, state_in;
   logic [16:0]    ax_ff, ax_in;
   logic [30:0]    u_ff, u_in;
   eps_type        eps_ff, eps_in;
   logic [63:0]    tm_ff, tm_in;
   logic           tn_ff, tn_in;
   logic [63:0]    sm_ff, sm_in;
   logic           sn_ff, sn_in;
   terms_used_type n_ff, n_in;
   logic [63:0]    lo_ff, lo_in;
   logic [63:0]    hi_ff, hi_in;
   logic [63:0]    quo_ff, quo_in;
   logic [6:0]     rem_ff, rem_in;
   logic [2:0]     step_ff, step_in;
   logic           cap_ff, cap_in;
   logic           rsp_valid_ff, rsp_valid_in;
   series_sum_type rsp_sum_ff, rsp_sum_in;
   terms_used_type rsp_terms_ff, rsp_terms_in;
   logic           rsp_cap_ff, rsp_cap_in;

   logic [31:0]    mul_a, mul_b;
   logic [63:0]    mul_p;
   logic [63:0]    thr;
   logic           term_gt;
   logic           out_free;
   logic [16:0]    arg_mag;

   // shared multiplier
   always_comb begin
      case (state_ff)
         S_MLO:   mul_a = tm_ff[31:0];
         S_MHI:   mul_a = tm_ff[63:32];
         default: mul_a = {15'd0, ax_ff};
      endcase
      if (state_ff == S_SQ) begin
         mul_b = {15'd0, ax_ff};
      end else begin
         mul_b = {1'b0, u_ff};
      end
   end

   assign mul_p    = mul_a * mul_b;
   assign thr      = {24'd0, eps_ff, 8'd0};
   assign term_gt  = tm_ff > thr;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign arg_mag  = req_arg_x[15] ? (17'h10000 - {1'b0, req_arg_x}) : {1'b0, req_arg_x};

   always_comb begin
      logic [7:0]  trial;
      logic [6:0]  r;
      logic [63:0] qv;
      logic [63:0] sat_sum;
      logic [63:0] add_sum;
      logic [64:0] diff;
      logic [53:0] q;
      logic        new_neg;

      state_in     = state_ff;
      ax_in        = ax_ff;
      u_in         = u_ff;
      eps_in       = eps_ff;
      tm_in        = tm_ff;
      tn_in        = tn_ff;
      sm_in        = sm_ff;
      sn_in        = sn_ff;
      n_in         = n_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      cap_in       = cap_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_sum_in   = rsp_sum_ff;
      rsp_terms_in = rsp_terms_ff;
      rsp_cap_in   = rsp_cap_ff;

      r       = rem_ff;
      qv      = quo_ff;
      trial   = 8'd0;
      sat_sum = 64'd0;
      add_sum = 64'd0;
      diff    = 65'd0;
      q       = 54'd0;
      new_neg = 1'b0;

      if (csr_valid) begin
         eps_in = csr_wdata;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ax_in    = arg_mag;
               tm_in    = ONE_Q40;
               sm_in    = ONE_Q40;
               tn_in    = 1'b0;
               sn_in    = 1'b0;
               n_in     = 7'd1;
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            u_in     = mul_p[30:0];
            state_in = S_CHK;
         end
         S_CHK: begin
            if (term_gt && (n_ff < TERM_CAP)) begin
               state_in = S_MLO;
            end else begin
               cap_in   = term_gt;
               state_in = S_OUT;
            end
         end
         S_MLO: begin
            lo_in    = mul_p;
            state_in = S_MHI;
         end
         S_MHI: begin
            hi_in    = mul_p;
            state_in = S_SAT;
         end
         S_SAT: begin
            sat_sum = {hi_ff[57:0], 6'd0} + {26'd0, lo_ff[63:26]};
            if ((|hi_ff[63:57]) || sat_sum[63]) begin
               quo_in = MAG_MAX;
            end else begin
               quo_in = sat_sum;
            end
            rem_in   = 7'd0;
            step_in  = 3'd0;
            state_in = S_DIV;
         end
         S_DIV: begin
            // 8 quotient bits per cycle
            for (int i = 0; i < 8; i++) begin
               trial = {r, qv[63]};
               qv    = {qv[62:0], 1'b0};
               if (trial >= {1'b0, n_ff}) begin
                  trial = trial - {1'b0, n_ff};
                  qv[0] = 1'b1;
               end
               r = trial[6:0];
            end
            quo_in  = qv;
            rem_in  = r;
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd7) begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            new_neg = !tn_ff && (quo_ff != 64'd0);
            tm_in   = quo_ff;
            tn_in   = new_neg;
            add_sum = sm_ff + quo_ff;
            diff    = {1'b0, sm_ff} - {1'b0, quo_ff};
            if (sn_ff == new_neg) begin
               sm_in = add_sum[63] ? MAG_MAX : add_sum;
               sn_in = sn_ff;
            end else if (!diff[64]) begin
               sm_in = diff[63:0];
               sn_in = sn_ff;
            end else begin
               sm_in = quo_ff - sm_ff;
               sn_in = new_neg;
            end
            if (sm_in == 64'd0) begin
               sn_in = 1'b0;
            end
            n_in     = n_ff + 7'd1;
            state_in = S_CHK;
         end
         S_OUT: begin
            if (out_free) begin
               if (sn_ff) begin
                  q = sm_ff[63:10] + {53'd0, |sm_ff[9:0]};
                  if (q > 54'h0_8000_0000) begin
                     rsp_sum_in = SUM_MIN;
                  end else begin
                     rsp_sum_in = series_sum_type'(~q[31:0] + 32'd1);
                  end
               end else begin
                  q = sm_ff[63:10];
                  if (q > 54'h0_7FFF_FFFF) begin
                     rsp_sum_in = SUM_MAX;
                  end else begin
                     rsp_sum_in = series_sum_type'(q[31:0]);
                  end
               end
               rsp_terms_in = n_ff;
               rsp_cap_in   = cap_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         eps_ff       <= EPS_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         eps_ff       <= eps_in;
      end
   end

   always_ff @(posedge clock) begin
      ax_ff        <= ax_in;
      u_ff         <= u_in;
      tm_ff        <= tm_in;
      tn_ff        <= tn_in;
      sm_ff        <= sm_in;
      sn_ff        <= sn_in;
      n_ff         <= n_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      step_ff      <= step_in;
      cap_ff       <= cap_in;
      rsp_sum_ff   <= rsp_sum_in;
      rsp_terms_ff <= rsp_terms_in;
      rsp_cap_ff   <= rsp_cap_in;
   end

   assign req_stall      = (state_ff != S_IDLE);
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_series_sum = rsp_sum_ff;
   assign rsp_terms_used = rsp_terms_ff;
   assign rsp_hit_cap    = rsp_cap_ff;

   // divider remainder stays below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (rem_ff < n_ff))
      else $error("divider remainder out of range");

   // term magnitude never exceeds the saturation limit once running
   a_term_sat: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHK) |-> !tm_ff[63])
      else $error("term magnitude overflow");

   // zero sum carries positive sign
   a_zero_pos: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHK && sm_ff == 64'd0) |-> !sn_ff)
      else $error("negative zero sum");

   // new response carries a legal term count
   a_terms_rng: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (rsp_terms_ff >= 7'd1 && rsp_terms_ff <= TERM_CAP))
      else $error("term count out of range");

   // cap flag only with the full term count
   a_cap_cnt: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_cap_ff) |-> (rsp_terms_ff == TERM_CAP))
      else $error("cap flag without full term count");

endmodule
